// ----- hw/rtl/ftc_pkg.sv -----
// Shared types and constants for the filmic tone curve pipeline.
// No dependencies; imported by the top level and its testbench.
package ftc_pkg;

  // Value class codes carried on the input tuser
  localparam logic [1:0] CLS_FINITE  = 2'd0;
  localparam logic [1:0] CLS_NAN     = 2'd1;
  localparam logic [1:0] CLS_POS_INF = 2'd2;
  localparam logic [1:0] CLS_RSVD    = 2'd3;

  // Register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_TOE_END  = 3'd0,
    REG_TOE_OUT  = 3'd1,
    REG_SLOPE    = 3'd2,
    REG_SHD_OUT  = 3'd3,
    REG_SHD_IN   = 3'd4,
    REG_PEAK     = 3'd5
  } reg_idx_t;

  // Curve segment chosen for a word
  typedef enum logic [2:0] {
    KIND_ZERO,
    KIND_PEAK,
    KIND_TOE,
    KIND_LIN,
    KIND_SHD
  } kind_t;

  // Exponential unit constants
  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  localparam logic [16:0] K_RECIP    = 17'((64'd1 << 48) / 64'(LN2_Q32));
  localparam int          EXP_TERMS  = 12;
  localparam int          EXP_CLAMP  = 80;
  localparam int          K_BITS     = 7;
  localparam logic [6:0]  K_ZERO_LIM = 7'd40;
  localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;

  // Toe unit constants (Q1.30 normalised position)
  localparam int          U_BITS     = 31;
  localparam logic [31:0] THREE_Q30  = 32'hC000_0000;

endpackage

// ----- hw/rtl/filmic_tone_curve_top.sv -----
// Filmic tone curve: toe, linear and exponential shoulder segments, fully pipelined.
// Depends on ftc_pkg.
//
// Usage:
//   Input stream in_*: in_tdata carries the luminance sample (unsigned fixed
//   point, FRAC_BITS fraction bits), in_tuser its value class. Output stream
//   out_*: out_tdata carries the mapped value, out_tuser the invalid-peak flag.
//   Curve registers are written over the cfg_* APB port while no words are in
//   flight; pready is tied high.
//   Throughput: one word per clock while the output buffer is not full. The
//   pipeline depth is set by the one-bit-per-stage shoulder divider, the
//   3-stage reciprocal ln2 reduction and the 12-term exponential, three
//   stages per term.
//   The toe and linear results are delayed to line up with the shoulder.
//   Reset: all valid bits clear, registers return to their default curve.
//   Stall: a two-word output buffer sits after the pipeline; in_tready drops
//   only when both entries are full, and the whole pipeline then holds.
//   No word is lost or repeated while the receiver stalls.
module filmic_tone_curve_top #(
  parameter int FRAC_BITS    = 16,
  parameter int MIN_HEADROOM = 1
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] luminance
  input  logic [1:0]  in_tuser,   // [1:0] value_class
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] tone_out
  output logic [0:0]  out_tuser,  // [0] peak_invalid
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ftc_pkg::*;

  localparam int EW     = FRAC_BITS + 7;
  localparam int E32W   = EW + 32 - FRAC_BITS;
  localparam int EHW    = E32W - 16;
  localparam int STW    = 64 - FRAC_BITS;
  localparam int SHW    = STW - 30;
  localparam int NEGW   = SHW + U_BITS + 1;
  localparam int LSW    = 65 - FRAC_BITS;
  localparam int SH_LVL = 46 + EW;
  localparam int TOE_LVL = 37;
  localparam int TD     = SH_LVL - TOE_LVL;
  localparam int LD     = SH_LVL - 4;
  localparam int KD     = SH_LVL - 2;
  localparam int HSTG   = 3 * EXP_TERMS;
  localparam logic [EW-1:0] E_LIM  = EW'(EXP_CLAMP) << FRAC_BITS;
  localparam logic [32:0]   ONE_QF = 33'd1 << FRAC_BITS;

  // ---------------------------------------------------------------- config
  logic [31:0] ep_r, tol_r, slope_r, sip_r, peak_r;
  logic [15:0] so_r;
  logic [31:0] sq;
  logic [31:0] head_r, head_nxt;
  logic        inv_r, inv_nxt;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  // Write registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ep_r    <= 32'd11796;
      tol_r   <= 32'd5898;
      slope_r <= 32'd65536;
      so_r    <= 16'd52429;
      sip_r   <= 32'd58327;
      peak_r  <= 32'd65536;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TOE_END: ep_r    <= cfg_pwdata;
        REG_TOE_OUT: tol_r   <= cfg_pwdata;
        REG_SLOPE:   slope_r <= cfg_pwdata;
        REG_SHD_OUT: so_r    <= cfg_pwdata[15:0];
        REG_SHD_IN:  sip_r   <= cfg_pwdata;
        REG_PEAK:    peak_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      REG_TOE_END: cfg_prdata = ep_r;
      REG_TOE_OUT: cfg_prdata = tol_r;
      REG_SLOPE:   cfg_prdata = slope_r;
      REG_SHD_OUT: cfg_prdata = {16'd0, so_r};
      REG_SHD_IN:  cfg_prdata = sip_r;
      REG_PEAK:    cfg_prdata = peak_r;
      default:     cfg_prdata = 32'd0;
    endcase
  end

  // Shoulder output level rescaled to the working fraction
  generate
    if (FRAC_BITS >= 16) begin : g_sq_up
      assign sq = 32'(so_r) << (FRAC_BITS - 16);
    end else begin : g_sq_dn
      assign sq = 32'(so_r >> (16 - FRAC_BITS));
    end
  endgenerate

  // Derived headroom and invalid-peak flag
  assign head_nxt = peak_r - sq;
  assign inv_nxt  = ({1'b0, peak_r} < ONE_QF) || (peak_r <= sq) ||
                    (head_nxt <= 32'(MIN_HEADROOM));

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    inv_r  <= inv_nxt;
  end

  // ---------------------------------------------------------------- flow
  logic              en;
  logic [SH_LVL:1]   vld_r;
  logic              ov_r, sv_r;

  assign en        = !sv_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[SH_LVL-1:1], in_tvalid};
  end

  // ---------------------------------------------------------------- front
  logic [31:0] x_r, dl_r, ds_r;
  logic [1:0]  cls_r;
  kind_t       kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= in_tdata;
      cls_r <= in_tuser;
    end
  end

  // Pick the segment
  always_comb begin
    if (cls_r == CLS_POS_INF)                 kind_nxt = KIND_PEAK;
    else if (cls_r != CLS_FINITE || x_r == '0) kind_nxt = KIND_ZERO;
    else if (x_r <= ep_r)                     kind_nxt = KIND_TOE;
    else if (x_r <= sip_r)                    kind_nxt = KIND_LIN;
    else                                      kind_nxt = KIND_SHD;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_r <= kind_nxt;
      dl_r   <= x_r - ep_r;
      ds_r   <= x_r - sip_r;
    end
  end

  // ---------------------------------------------------------------- linear
  logic [63:0]    lp_r, num_r;
  logic [LSW-1:0] lsum;
  logic [31:0]    ly_r;

  assign lsum = LSW'(tol_r) + LSW'(lp_r >> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      lp_r  <= 64'(slope_r) * 64'(dl_r);
      num_r <= 64'(slope_r) * 64'(ds_r);
      ly_r  <= (|lsum[LSW-1:32]) ? 32'hFFFF_FFFF : lsum[31:0];
    end
  end

  // ---------------------------------------------------------------- shoulder divide
  // e = slope*(x - shoulder_in) / head, one quotient bit per stage
  logic [31:0]   drem_r [0:EW];
  logic [EW-1:0] dlow_r [0:EW];
  logic          dsat_r [0:EW];
  logic [63:0]   num_hi;

  assign num_hi = num_r >> EW;

  always_ff @(posedge clk) begin
    if (en) begin
      dsat_r[0] <= num_hi >= 64'(head_r);
      drem_r[0] <= num_hi[31:0];
      dlow_r[0] <= num_r[EW-1:0];
    end
  end

  genvar gi;
  generate
    for (gi = 1; gi <= EW; gi++) begin : g_sdiv
      logic [32:0] cand;
      logic        ge;
      assign cand = {drem_r[gi-1], dlow_r[gi-1][EW-1]};
      assign ge   = cand >= {1'b0, head_r};
      always_ff @(posedge clk) begin
        if (en) begin
          drem_r[gi] <= ge ? 32'(cand - {1'b0, head_r}) : cand[31:0];
          dlow_r[gi] <= {dlow_r[gi-1][EW-2:0], ge};
          dsat_r[gi] <= dsat_r[gi-1];
        end
      end
    end
  endgenerate

  // ---------------------------------------------------------------- ln2 reduction
  logic [EW-1:0]     ec;
  logic [E32W-1:0]   e32;
  logic [EHW+16:0]   kp;
  logic [E32W-1:0]   kl;
  logic [E32W-1:0]   ea_r;
  logic [K_BITS-1:0] ka_r, kb_r, kq_r;
  logic [32:0]       rb_r;
  logic [31:0]       krem_r;
  logic              kge;

  // Clamp the exponent and move it to Q.32
  assign ec  = (dsat_r[EW] || dlow_r[EW] > E_LIM) ? E_LIM : dlow_r[EW];
  assign e32 = E32W'(ec) << (32 - FRAC_BITS);

  // Estimate k by reciprocal, form the remainder, then correct by one step
  assign kp  = (EHW+17)'(e32[E32W-1:16]) * (EHW+17)'(K_RECIP);
  assign kl  = E32W'(ka_r) * E32W'(LN2_Q32);
  assign kge = rb_r >= {1'b0, LN2_Q32};

  always_ff @(posedge clk) begin
    if (en) begin
      ka_r   <= K_BITS'(kp >> 32);
      ea_r   <= e32;
      rb_r   <= 33'(ea_r - kl);
      kb_r   <= ka_r;
      krem_r <= kge ? 32'(rb_r - {1'b0, LN2_Q32}) : rb_r[31:0];
      kq_r   <= kge ? kb_r + K_BITS'(1) : kb_r;
    end
  end

  // ---------------------------------------------------------------- exp(-r) Horner
  logic [31:0]       crw   [0:HSTG];
  logic [K_BITS-1:0] ckw   [0:HSTG];
  logic [31:0]       cr_r  [1:HSTG];
  logic [K_BITS-1:0] ck_r  [1:HSTG];
  logic [31:0]       hv_r  [0:EXP_TERMS-1];
  logic [31:0]       hv2_r [0:EXP_TERMS-1];
  logic [31:0]       hq_r  [0:EXP_TERMS-1];
  logic [32:0]       hp_r  [0:EXP_TERMS-1];

  assign crw[0] = krem_r;
  assign ckw[0] = kq_r;

  // Carry remainder and shift count alongside the terms
  generate
    for (gi = 1; gi <= HSTG; gi++) begin : g_carry
      assign crw[gi] = cr_r[gi];
      assign ckw[gi] = ck_r[gi];
      always_ff @(posedge clk) begin
        if (en) begin
          cr_r[gi] <= crw[gi-1];
          ck_r[gi] <= ckw[gi-1];
        end
      end
    end

    // One term in three stages: multiply by r, divide by n, correct and subtract
    for (gi = 0; gi < EXP_TERMS; gi++) begin : g_term
      localparam int          N     = EXP_TERMS - gi;
      localparam logic [32:0] RECIP = 33'((64'd1 << 32) / N);
      logic [32:0] pin;
      logic [64:0] prod_a, prod_b;
      logic [35:0] rm;
      logic [31:0] q;
      if (gi == 0) begin : g_first
        assign pin = ONE_Q32;
      end else begin : g_next
        assign pin = hp_r[gi-1];
      end
      assign prod_a = 65'(crw[3*gi]) * 65'(pin);
      assign prod_b = 65'(hv_r[gi]) * 65'(RECIP);
      assign rm     = 36'(hv2_r[gi]) - 36'(hq_r[gi]) * 36'(N);
      assign q      = (rm >= 36'(N)) ? hq_r[gi] + 32'd1 : hq_r[gi];
      always_ff @(posedge clk) begin
        if (en) begin
          hv_r[gi]  <= prod_a[63:32];
          hq_r[gi]  <= prod_b[63:32];
          hv2_r[gi] <= hv_r[gi];
          hp_r[gi]  <= ONE_Q32 - 33'(q);
        end
      end
    end
  endgenerate

  // ---------------------------------------------------------------- shoulder output
  logic [32:0] ex_r;
  logic [64:0] hm_prod;
  logic [31:0] hm_r, ysh_r;

  assign hm_prod = 65'(head_r) * 65'(ex_r);

  always_ff @(posedge clk) begin
    if (en) begin
      ex_r  <= (ckw[HSTG] >= K_ZERO_LIM) ? 33'd0 : hp_r[EXP_TERMS-1] >> ckw[HSTG];
      hm_r  <= hm_prod[63:32];
      ysh_r <= peak_r - hm_r;
    end
  end

  // ---------------------------------------------------------------- toe divide
  // u = (x << 30) / toe_end, one quotient bit per stage
  logic [31:0]       trw    [0:U_BITS];
  logic [U_BITS-1:0] tlw    [0:U_BITS];
  logic [31:0]       trem_r [1:U_BITS];
  logic [U_BITS-1:0] tlow_r [1:U_BITS];

  assign trw[0] = x_r >> 1;
  assign tlw[0] = {x_r[0], 30'd0};

  generate
    for (gi = 1; gi <= U_BITS; gi++) begin : g_tdiv
      logic [32:0] cand;
      logic        ge;
      assign trw[gi] = trem_r[gi];
      assign tlw[gi] = tlow_r[gi];
      assign cand = {trw[gi-1], tlw[gi-1][U_BITS-1]};
      assign ge   = cand >= {1'b0, ep_r};
      always_ff @(posedge clk) begin
        if (en) begin
          trem_r[gi] <= ge ? 32'(cand - {1'b0, ep_r}) : cand[31:0];
          tlow_r[gi] <= {tlw[gi-1][U_BITS-2:0], ge};
        end
      end
    end
  endgenerate

  // ---------------------------------------------------------------- toe polynomial
  logic [U_BITS-1:0] tu_r, tu2_r, tu2b_r, tu3_r, m_r;
  logic [STW-1:0]    st_r, st2_r, st3_r;
  logic [31:0]       rise_r;
  logic [33:0]       pos_r, pos2_r;
  logic [SHW+U_BITS-1:0] a_r;
  logic [U_BITS-1:0] b_r;
  logic [31:0]       ty_r;
  logic [61:0]       sq_u, cube_u;
  logic [63:0]       rise_p, pos_p, st_p;
  logic [60:0]       b_p;
  logic [NEGW-1:0]   neg;

  assign sq_u   = 62'(tlw[U_BITS]) * 62'(tlw[U_BITS]);
  assign st_p   = 64'(slope_r) * 64'(ep_r);
  assign cube_u = 62'(tu2_r) * 62'(tu_r);
  assign rise_p = 64'(tu2_r) * 64'(THREE_Q30 - {tu_r, 1'b0});
  assign pos_p  = 64'(tol_r) * 64'(rise_r);
  assign b_p    = 61'(st3_r[29:0]) * 61'(m_r);
  assign neg    = NEGW'(a_r) + NEGW'(b_r);

  always_ff @(posedge clk) begin
    if (en) begin
      // square and slope*toe_end
      tu_r   <= tlw[U_BITS];
      tu2_r  <= U_BITS'(sq_u >> 30);
      st_r   <= STW'(st_p >> FRAC_BITS);
      // cube and rise
      tu3_r  <= U_BITS'(cube_u >> 30);
      rise_r <= 32'(rise_p >> 30);
      tu2b_r <= tu2_r;
      st2_r  <= st_r;
      // positive part and u^2 - u^3
      pos_r  <= 34'(pos_p >> 30);
      m_r    <= tu2b_r - tu3_r;
      st3_r  <= st2_r;
      // negative part, split at bit 30
      a_r    <= (SHW+U_BITS)'(st3_r[STW-1:30]) * (SHW+U_BITS)'(m_r);
      b_r    <= U_BITS'(b_p >> 30);
      pos2_r <= pos_r;
      // floor at zero
      ty_r   <= (NEGW'(pos2_r) > neg) ? 32'(NEGW'(pos2_r) - neg) : 32'd0;
    end
  end

  // ---------------------------------------------------------------- align
  logic [31:0] td_r [1:TD];
  logic [31:0] ld_r [1:LD];
  kind_t       kd_r [1:KD];

  always_ff @(posedge clk) begin
    if (en) begin
      td_r[1] <= ty_r;
      ld_r[1] <= ly_r;
      kd_r[1] <= kind_r;
      for (int i = 2; i <= TD; i++) td_r[i] <= td_r[i-1];
      for (int i = 2; i <= LD; i++) ld_r[i] <= ld_r[i-1];
      for (int i = 2; i <= KD; i++) kd_r[i] <= kd_r[i-1];
    end
  end

  // ---------------------------------------------------------------- select
  logic [31:0] fin_y;

  always_comb begin
    if (inv_r) begin
      fin_y = 32'd0;
    end else begin
      case (kd_r[KD])
        KIND_PEAK: fin_y = peak_r;
        KIND_TOE:  fin_y = td_r[TD];
        KIND_LIN:  fin_y = ld_r[LD];
        KIND_SHD:  fin_y = ysh_r;
        default:   fin_y = 32'd0;
      endcase
    end
  end

  // ---------------------------------------------------------------- output buffer
  logic        push, pop;
  logic [31:0] oy_r, sy_r;
  logic        oi_r, si_r;

  assign push = en & vld_r[SH_LVL];
  assign pop  = ov_r & out_tready;

  // Head entry refills from the skid entry first, then from the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (!ov_r || pop) begin
      if (sv_r) begin
        ov_r <= 1'b1;
        sv_r <= 1'b0;
      end else begin
        ov_r <= push;
      end
    end else if (push) begin
      sv_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov_r || pop) begin
      if (sv_r) begin
        oy_r <= sy_r;
        oi_r <= si_r;
      end else if (push) begin
        oy_r <= fin_y;
        oi_r <= inv_r;
      end
    end else if (push) begin
      sy_r <= fin_y;
      si_r <= inv_r;
    end
  end

  assign out_tvalid   = ov_r;
  assign out_tdata    = oy_r;
  assign out_tuser[0] = oi_r;

endmodule

// ----- hw/rtl/ftc_checker.sv -----
// Port-level checks for the filmic tone curve top level.
// Depends on filmic_tone_curve_top; attached by the bind below.
module ftc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // Back-pressure only comes from a waiting output word
  a_stall_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no output word waiting");

  // Taking a word from a full buffer frees the input next cycle
  a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_tready && out_tready) |=> in_tready)
    else $error("input still stalled after output word taken");

  // Invalid peak always forces a zero result
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == 32'd0))
    else $error("invalid peak with non-zero output");

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) &&
                                     $stable(out_tuser)))
    else $error("output word changed while stalled");

endmodule

bind filmic_tone_curve_top ftc_checker u_ftc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- dv/filmic_tone_curve_top_test.sv -----
// Self-checking testbench for filmic_tone_curve_top: toe, linear and shoulder mapping.
// Depends on ftc_pkg and filmic_tone_curve_top; holds its own bit-exact curve predictor.
`timescale 1ns / 1ps

module filmic_tone_curve_top_test;
  import ftc_pkg::*;

  localparam int          FRAC_BITS    = 16;
  localparam int          MIN_HEADROOM = 1;
  localparam int          LATENCY      = FRAC_BITS + 53;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam longint unsigned ONE_Q32_L = 64'h1_0000_0000;
  localparam longint unsigned ONE_Q30_L = 64'h4000_0000;
  localparam longint unsigned MASK_Q30  = ONE_Q30_L - 1;

  typedef struct packed {
    logic [31:0] tone;
    logic        invalid;
  } tone_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] luminance
  logic [1:0]  in_tuser = '0;   // [1:0] value_class
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [31:0] tone_out
  logic [0:0]  out_tuser;       // [0] peak_invalid
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Shadow copy of the curve registers
  longint unsigned toe_end, toe_out, slope, shd_out, shd_in, peak;

  tone_word_t expected_tones[$];
  int mismatches = 0;
  int cycles = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int hold_request = 0;

  filmic_tone_curve_top #(.FRAC_BITS(FRAC_BITS), .MIN_HEADROOM(MIN_HEADROOM)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a run that never drains
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // exp(-e) in Q0.32, e in Q.32
  function automatic longint unsigned exp_neg(longint unsigned e);
    longint unsigned k, r, p, n;
    k = e / longint'(LN2_Q32);
    r = e - k * longint'(LN2_Q32);
    p = ONE_Q32_L;
    for (n = EXP_TERMS; n >= 1; n--) p = ONE_Q32_L - ((r * p) >> 32) / n;
    if (k >= 40) return 0;
    return p >> k;
  endfunction

  function automatic longint unsigned toe_value(longint unsigned x);
    longint unsigned u, u2, u3, rise, pos, st, m, neg;
    u    = (x << 30) / toe_end;
    u2   = (u * u) >> 30;
    u3   = (u2 * u) >> 30;
    rise = (u2 * (3 * ONE_Q30_L - 2 * u)) >> 30;
    pos  = (toe_out * rise) >> 30;
    st   = (slope * toe_end) >> FRAC_BITS;
    m    = u2 - u3;
    neg  = (st >> 30) * m + (((st & MASK_Q30) * m) >> 30);
    return (pos > neg) ? pos - neg : 0;
  endfunction

  function automatic tone_word_t predict_tone(logic [31:0] lum, logic [1:0] cls);
    tone_word_t w;
    longint unsigned x, s, head, y, e;
    x = lum;
    s = shd_out << (FRAC_BITS - 16);
    w.invalid = 1'b0;
    if (peak < (64'd1 << FRAC_BITS) || peak <= s || peak - s <= MIN_HEADROOM) begin
      w.tone = '0;
      w.invalid = 1'b1;
      return w;
    end
    head = peak - s;
    if (cls == CLS_POS_INF) y = peak;
    else if (cls != CLS_FINITE || x == 0) y = 0;
    else if (x <= toe_end) y = toe_value(x);
    else if (x <= shd_in) begin
      y = toe_out + ((slope * (x - toe_end)) >> FRAC_BITS);
      if (y > 64'hFFFF_FFFF) y = 64'hFFFF_FFFF;
    end else begin
      e = (slope * (x - shd_in)) / head;
      if (e > (longint'(EXP_CLAMP) << FRAC_BITS)) e = longint'(EXP_CLAMP) << FRAC_BITS;
      e = e << (32 - FRAC_BITS);
      y = peak - ((head * exp_neg(e)) >> 32);
    end
    w.tone = y[31:0];
    return w;
  endfunction

  // Compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    tone_word_t exp_w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_tones.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: tone %h invalid %b", out_tdata, out_tuser[0]);
      end else begin
        exp_w = expected_tones.pop_front();
        if (exp_w.tone !== out_tdata || exp_w.invalid !== out_tuser[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected tone %h invalid %b, got tone %h invalid %b",
                     exp_w.tone, exp_w.invalid, out_tdata, out_tuser[0]);
        end
      end
    end
  end

  // Receiver: shifting stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    int mode_left, mode, hold_left;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (mode_left <= 0) begin
      mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 300);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 1) == 1);
        2: out_tready <= ($urandom_range(0, 7) != 0);
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Offer one word and hold it until accepted; called at a rising edge
  task automatic send_sample(logic [31:0] lum, logic [1:0] cls);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= lum;
    in_tuser  <= cls;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    expected_tones.push_back(predict_tone(lum, cls));
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_tones.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // APB write: setup then access cycle; only while idle
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_TOE_END: toe_end = val;
      REG_TOE_OUT: toe_out = val;
      REG_SLOPE:   slope   = val;
      REG_SHD_OUT: shd_out = val[15:0];
      REG_SHD_IN:  shd_in  = val;
      REG_PEAK:    peak    = val;
      default: ;
    endcase
  endtask

  task automatic set_curve(logic [31:0] te, logic [31:0] to, logic [31:0] sl,
                           logic [15:0] so, logic [31:0] si, logic [31:0] pk);
    drain();
    write_reg(REG_TOE_END, te);
    write_reg(REG_TOE_OUT, to);
    write_reg(REG_SLOPE, sl);
    write_reg(REG_SHD_OUT, {16'd0, so});
    write_reg(REG_SHD_IN, si);
    write_reg(REG_PEAK, pk);
  endtask

  // Pick a luminance aimed at one of the segments
  function automatic logic [31:0] pick_luminance();
    longint unsigned v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1, 2: v = (toe_end == 0) ? 1 : $urandom_range(1, toe_end);
      3, 4: v = toe_end + $urandom_range(0, 32'h0008_0000);
      5, 6, 7: v = shd_in + $urandom_range(1, 32'h0010_0000);
      8: v = shd_in + ($urandom_range(0, 3) << 16);
      default: v = $urandom();
    endcase
    if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    return v[31:0];
  endfunction

  function automatic logic [1:0] pick_class();
    case ($urandom_range(0, 19))
      0: return CLS_NAN;
      1: return CLS_POS_INF;
      2: return CLS_RSVD;
      default: return CLS_FINITE;
    endcase
  endfunction

  // Segment edges and value classes on the reset curve
  task automatic test_reset_curve;
    send_sample(32'd0, CLS_FINITE);
    send_sample(32'd1, CLS_FINITE);
    send_sample(32'd5000, CLS_FINITE);
    send_sample(32'd11796, CLS_FINITE);
    send_sample(32'd11797, CLS_FINITE);
    send_sample(32'd58327, CLS_FINITE);
    send_sample(32'd58328, CLS_FINITE);
    send_sample(32'h8000_0000, CLS_FINITE);
    send_sample(32'hFFFF_FFFF, CLS_FINITE);
    send_sample(32'h0001_2345, CLS_NAN);
    send_sample(32'h0001_2345, CLS_POS_INF);
    send_sample(32'hFFFF_FFFF, CLS_RSVD);
  endtask

  // Register extremes, invalid peak and inconsistent segment points
  task automatic test_extremes;
    set_curve(32'd1, 32'd1, 32'd1, 16'd1, 32'd1, 32'hFFFF_FFFF);
    send_sample(32'd1, CLS_FINITE);
    send_sample(32'd2, CLS_FINITE);
    send_sample(32'hFFFF_FFFF, CLS_FINITE);
    set_curve(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    send_sample(32'h7FFF_FFFF, CLS_FINITE);
    send_sample(32'hFFFF_FFFF, CLS_FINITE);
    set_curve(32'd100, 32'd50, 32'hFFFF_FFFF, 16'd1, 32'h0100_0000, 32'h0002_0000);
    send_sample(32'h00FF_FFFF, CLS_FINITE);
    send_sample(32'h0100_0001, CLS_FINITE);
    // Peak only one raw step above the shoulder output
    set_curve(32'd11796, 32'd5898, 32'd65536, 16'hFFFF, 32'd58327, 32'd65536);
    send_sample(32'd70000, CLS_FINITE);
    send_sample(32'd0, CLS_POS_INF);
    // Peak below one
    set_curve(32'd11796, 32'd5898, 32'd65536, 16'd100, 32'd58327, 32'd65535);
    send_sample(32'd3000, CLS_FINITE);
    // Zero toe end, shoulder start before toe end
    set_curve(32'd0, 32'd9000, 32'd70000, 16'd40000, 32'd0, 32'h0003_0000);
    send_sample(32'd1, CLS_FINITE);
    send_sample(32'h0002_0000, CLS_FINITE);
    set_curve(32'h0004_0000, 32'd9000, 32'd70000, 16'd40000, 32'h0001_0000,
              32'h0003_0000);
    send_sample(32'h0002_0000, CLS_FINITE);
    send_sample(32'h0005_0000, CLS_FINITE);
  endtask

  // Random curves with random samples
  task automatic test_random_curves(int phases, int per_phase);
    logic [31:0] te;
    for (int ph = 0; ph < phases; ph++) begin
      te = $urandom_range(1, 32'h0004_0000);
      if (ph == phases - 1)
        set_curve($urandom(), $urandom(), $urandom(), 16'($urandom()), $urandom(),
                  $urandom_range(32'h0001_0000, 32'hFFFF_FFFF));
      else
        set_curve(te, $urandom_range(1, 32'h0002_0000), $urandom_range(1, 32'h0004_0000),
                  16'($urandom_range(1, 65535)), te + $urandom_range(0, 32'h0008_0000),
                  $urandom_range(32'h0001_0000, 32'h0008_0000));
      gaps_on = (ph % 3) != 1;
      for (int i = 0; i < per_phase; i++) send_sample(pick_luminance(), pick_class());
    end
    gaps_on = 1'b1;
  endtask

  // Long receiver hold-off while samples keep coming
  task automatic test_backpressure;
    set_curve(32'd11796, 32'd5898, 32'd65536, 16'd52429, 32'd58327, 32'h0002_0000);
    gaps_on = 1'b0;
    hold_request = 400;
    for (int i = 0; i < 150; i++) send_sample(pick_luminance(), pick_class());
    gaps_on = 1'b1;
  endtask

  initial begin
    toe_end = 11796; toe_out = 5898; slope = 65536;
    shd_out = 52429; shd_in = 58327; peak = 65536;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_curve();
    test_extremes();
    test_random_curves(6, 150);
    test_backpressure();
    drain();
    if (mismatches == 0 && expected_tones.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
